>>> src/bms_pkg.sv
// Shared types and constants for the block mean and standard deviation engine.
// Used by bms_unit, bms_seq, the top level and the port checker; no dependencies.
`default_nettype none

package bms_pkg;

    // Field and accumulator widths
    localparam int SAMPLE_BITS = 12;
    localparam int MAX_BLOCK   = 4096;
    localparam int CNT_W       = 13;
    localparam int SUM_W       = 24;
    localparam int SQ_W        = 36;
    localparam int MEAN_W      = 20;
    localparam int STD_W       = 19;
    localparam int SQR_W       = 2 * SAMPLE_BITS;

    // End-of-block arithmetic widths
    localparam int LHS_W    = CNT_W + SQ_W;       // N * sum of squares
    localparam int RHS_W    = 2 * SUM_W;          // sum * sum
    localparam int M_W      = 2 * CNT_W;          // N * N
    localparam int VAR_FRAC = 16;                 // Q16 variance before the root
    localparam int DIVD_W   = LHS_W + VAR_FRAC;   // widest dividend
    localparam int U_W      = 64;                 // shared adder width

    // Iteration counts of the shared unit
    localparam int MUL_STEPS  = SUM_W;            // widest multiplier operand
    localparam int DIV_STEPS  = DIVD_W;
    localparam int SQRT_STEPS = U_W / 2;
    localparam int STEP_W     = $clog2(DIVD_W + 1);

    // Stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((MEAN_W + STD_W + 7) / 8) * 8;

    localparam logic [CNT_W-1:0]  BLEN_RESET = CNT_W'(99);
    localparam logic [MEAN_W-1:0] MEAN_MAX   = MEAN_W'(1048320);
    localparam logic [STD_W-1:0]  STD_MAX    = STD_W'(524160);

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT,
        OP_SUBC
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_req;

    typedef struct packed {
        logic [STD_W-1:0]  std_q8;
        logic [MEAN_W-1:0] mean_q8;
    } t_result;

endpackage

`default_nettype wire

>>> src/bms_unit.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root and clamped subtract over one adder. Uses bms_pkg.
`default_nettype none

module bms_unit (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bms_pkg::t_unit_req         i_req,
    input  wire logic [bms_pkg::DIVD_W-1:0] i_a,
    input  wire logic [bms_pkg::U_W-1:0]    i_b,
    output logic                            o_done,
    output logic [bms_pkg::U_W-1:0]         o_result
);
    import bms_pkg::*;

    logic              r_busy;
    logic              r_done;
    t_op               r_op;
    logic [STEP_W-1:0] r_cnt;
    logic [DIVD_W-1:0] r_x;     // multiplicand / dividend+quotient / radicand
    logic [U_W-1:0]    r_y;     // multiplier / divisor / root
    logic [U_W-1:0]    r_acc;   // product / remainder

    logic [DIVD_W-1:0] n_x;
    logic [U_W-1:0]    n_y;
    logic [U_W-1:0]    n_acc;

    logic [U_W-1:0]    w_rem_div;
    logic [U_W-1:0]    w_rem_sq;
    logic [U_W-1:0]    w_trial;
    logic [U_W-1:0]    w_opx;
    logic [U_W-1:0]    w_opy;
    logic              w_sub;
    logic [U_W:0]      w_sum;
    logic              w_carry;

    assign w_rem_div = {r_acc[U_W-2:0], r_x[DIVD_W-1]};
    assign w_rem_sq  = {r_acc[U_W-3:0], r_x[U_W-1:U_W-2]};
    assign w_trial   = {r_y[U_W-3:0], 2'b01};

    // Operand select for the one adder
    always_comb begin
        case (r_op)
            OP_MUL: begin
                w_opx = r_acc;
                w_opy = r_x[U_W-1:0];
                w_sub = 1'b0;
            end
            OP_DIV: begin
                w_opx = w_rem_div;
                w_opy = r_y;
                w_sub = 1'b1;
            end
            OP_SQRT: begin
                w_opx = w_rem_sq;
                w_opy = w_trial;
                w_sub = 1'b1;
            end
            default: begin
                w_opx = r_x[U_W-1:0];
                w_opy = r_y;
                w_sub = 1'b1;
            end
        endcase
    end

    // Carry out of a subtract means no borrow: x >= y
    assign w_sum   = {1'b0, w_opx} + {1'b0, (w_sub ? ~w_opy : w_opy)} + (U_W+1)'(w_sub);
    assign w_carry = w_sum[U_W];

    always_comb begin
        n_x   = r_x;
        n_y   = r_y;
        n_acc = r_acc;
        case (r_op)
            OP_MUL: begin
                n_acc = r_y[0] ? w_sum[U_W-1:0] : r_acc;
                n_x   = {r_x[DIVD_W-2:0], 1'b0};
                n_y   = {1'b0, r_y[U_W-1:1]};
            end
            OP_DIV: begin
                n_acc = w_carry ? w_sum[U_W-1:0] : w_rem_div;
                n_x   = {r_x[DIVD_W-2:0], w_carry};
            end
            OP_SQRT: begin
                n_acc = w_carry ? w_sum[U_W-1:0] : w_rem_sq;
                n_x   = {r_x[DIVD_W-3:0], 2'b00};
                n_y   = {r_y[U_W-2:0], w_carry};
            end
            default: begin
                n_acc = w_carry ? w_sum[U_W-1:0] : '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_MUL;
            r_cnt  <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_acc  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_x   <= n_x;
                r_y   <= n_y;
                r_acc <= n_acc;
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_x    <= i_a;
                r_acc  <= '0;
                case (i_req.op)
                    OP_MUL: begin
                        r_y   <= i_b;
                        r_cnt <= STEP_W'(MUL_STEPS);
                    end
                    OP_DIV: begin
                        r_y   <= i_b;
                        r_cnt <= STEP_W'(DIV_STEPS);
                    end
                    OP_SQRT: begin
                        r_y   <= '0;
                        r_cnt <= STEP_W'(SQRT_STEPS);
                    end
                    default: begin
                        r_y   <= i_b;
                        r_cnt <= STEP_W'(1);
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (r_op)
            OP_DIV:  o_result = r_x[U_W-1:0];
            OP_SQRT: o_result = r_y;
            default: o_result = r_acc;
        endcase
    end

    assign o_done = r_done;

endmodule

`default_nettype wire

>>> src/bms_seq.sv
// Sample accumulator and end-of-block sequencer driving the shared unit.
// Uses bms_pkg and instantiates bms_unit.
`default_nettype none

module bms_seq (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_sample_valid,
    output logic                                 o_sample_ready,
    input  wire logic [bms_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic [bms_pkg::CNT_W-1:0]       i_block_length,
    output logic                                 o_res_valid,
    input  wire logic                            i_res_ready,
    output bms_pkg::t_result                     o_res
);
    import bms_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ACC,
        S_LHS,
        S_RHS,
        S_MSQ,
        S_DIFF,
        S_VAR,
        S_MEAN,
        S_ROOT,
        S_OUT
    } t_state;

    t_state            r_state;
    logic              r_issued;
    logic [SUM_W-1:0]  r_sum;
    logic [SQ_W-1:0]   r_sumsq;
    logic [CNT_W-1:0]  r_cnt;
    logic [SQR_W-1:0]  r_sq;
    logic [LHS_W-1:0]  r_lhs;     // N * sumsq, then the clamped difference
    logic [RHS_W-1:0]  r_rhs;
    logic [M_W-1:0]    r_m;
    logic [U_W-1:0]    r_q;
    logic [MEAN_W-1:0] r_mean;
    logic [STD_W-1:0]  r_std;

    logic [CNT_W-1:0]  w_eff;
    t_unit_req         w_req;
    logic [DIVD_W-1:0] w_a;
    logic [U_W-1:0]    w_b;
    logic              w_done;
    logic [U_W-1:0]    w_result;
    logic              w_take;

    // Effective block length: zero counts as one, saturate at the maximum
    always_comb begin
        if (i_block_length == '0) begin
            w_eff = CNT_W'(1);
        end else if (i_block_length > CNT_W'(MAX_BLOCK)) begin
            w_eff = CNT_W'(MAX_BLOCK);
        end else begin
            w_eff = i_block_length;
        end
    end

    // Operation and operands for the shared unit
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = OP_MUL;
        w_a         = '0;
        w_b         = '0;
        case (r_state)
            S_LHS: begin
                w_req.start = !r_issued;
                w_a         = DIVD_W'(r_sumsq);
                w_b         = U_W'(r_cnt);
            end
            S_RHS: begin
                w_req.start = !r_issued;
                w_a         = DIVD_W'(r_sum);
                w_b         = U_W'(r_sum);
            end
            S_MSQ: begin
                w_req.start = !r_issued;
                w_a         = DIVD_W'(r_cnt);
                w_b         = U_W'(r_cnt);
            end
            S_DIFF: begin
                w_req.start = !r_issued;
                w_req.op    = OP_SUBC;
                w_a         = DIVD_W'(r_lhs);
                w_b         = U_W'(r_rhs);
            end
            S_VAR: begin
                w_req.start = !r_issued;
                w_req.op    = OP_DIV;
                w_a         = {r_lhs, VAR_FRAC'(0)};
                w_b         = U_W'(r_m);
            end
            S_MEAN: begin
                w_req.start = !r_issued;
                w_req.op    = OP_DIV;
                w_a         = DIVD_W'({r_sum, 8'd0});
                w_b         = U_W'(r_cnt);
            end
            S_ROOT: begin
                w_req.start = !r_issued;
                w_req.op    = OP_SQRT;
                w_a         = DIVD_W'(r_q);
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    bms_unit u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .i_a      (w_a),
        .i_b      (w_b),
        .o_done   (w_done),
        .o_result (w_result)
    );

    assign w_take = i_sample_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_sum    <= '0;
            r_sumsq  <= '0;
            r_cnt    <= '0;
            r_sq     <= '0;
            r_lhs    <= '0;
            r_rhs    <= '0;
            r_m      <= '0;
            r_q      <= '0;
            r_mean   <= '0;
            r_std    <= '0;
        end else begin
            if (w_req.start) begin
                r_issued <= 1'b1;
            end
            if (w_done) begin
                r_issued <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_sq    <= SQR_W'(i_sample) * SQR_W'(i_sample);
                        r_sum   <= r_sum + SUM_W'(i_sample);
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_sumsq <= r_sumsq + SQ_W'(r_sq);
                    if ((r_cnt != '0) && (r_cnt >= w_eff)) begin
                        r_state <= S_LHS;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_LHS: begin
                    if (w_done) begin
                        r_lhs   <= w_result[LHS_W-1:0];
                        r_state <= S_RHS;
                    end
                end
                S_RHS: begin
                    if (w_done) begin
                        r_rhs   <= w_result[RHS_W-1:0];
                        r_state <= S_MSQ;
                    end
                end
                S_MSQ: begin
                    if (w_done) begin
                        r_m     <= w_result[M_W-1:0];
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    if (w_done) begin
                        r_lhs   <= w_result[LHS_W-1:0];
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    if (w_done) begin
                        r_q     <= w_result;
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    if (w_done) begin
                        r_mean  <= w_result[MEAN_W-1:0];
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (w_done) begin
                        r_std   <= w_result[STD_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Hand over the result, then clear for the next block
                    if (i_res_ready) begin
                        r_sum   <= '0;
                        r_sumsq <= '0;
                        r_cnt   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_sample_ready = (r_state == S_IDLE);
    assign o_res_valid    = (r_state == S_OUT);
    assign o_res.mean_q8  = r_mean;
    assign o_res.std_q8   = r_std;

endmodule

`default_nettype wire

>>> src/block_mean_and_std.sv
// Block mean and population standard deviation over unsigned converter samples.
// Top level: configuration register, stream handshakes, output register.
// Depends on bms_pkg and bms_seq (which holds bms_unit).
//
// Usage:
//   Samples enter on the s_axis channel, one per transfer. After every block
//   of block_length samples one result leaves on the m_axis channel: the mean
//   and the population standard deviation, both unsigned Q8, truncated.
//   block_length is written on the cfg channel (o_cfg_ready is always high);
//   zero counts as one and values above 4096 saturate to 4096. Write it only
//   while the block is idle.
// Sample flow:
//   A sample that does not end a block is squared, then added into the sum
//   of squares; s_axis_tready drops for one cycle after such a transfer.
//   The sample that ends a block starts the end-of-block pass on the shared
//   shift/add unit: three 24-step multiplies, one subtract, two 65-step
//   divides and a 32-step root, during which s_axis_tready stays low. The
//   result then moves into the output register.
// Reset (i_rst_n low, synchronous): sums and count clear, block_length
//   returns to 99, the output register empties.
// Stall: while m_axis_tready is low the result holds in the output register;
//   the next block still accumulates and waits only at its own end.
`default_nettype none

module block_mean_and_std (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // s_axis_tdata: [11:0] sample
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [bms_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // m_axis_tdata: [19:0] mean_q8, [38:20] std_q8, upper bits zero
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [bms_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
    // Configuration: block_length
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bms_pkg::CNT_W-1:0]           i_cfg_data
);
    import bms_pkg::*;

    logic [CNT_W-1:0] r_block_length;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_res_valid;
    logic             w_res_ready;
    t_result          w_res;

    // Register write on every cfg transfer
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= BLEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_block_length <= i_cfg_data;
        end
    end

    bms_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (s_axis_tvalid),
        .o_sample_ready (s_axis_tready),
        .i_sample       (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_block_length (r_block_length),
        .o_res_valid    (w_res_valid),
        .i_res_ready    (w_res_ready),
        .o_res          (w_res)
    );

    // Output register: load when empty or draining this cycle
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (w_res_valid && w_res_ready) begin
                r_out_valid <= 1'b1;
                r_out       <= w_res;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_out.std_q8, r_out.mean_q8});

endmodule

`default_nettype wire

>>> src/block_mean_and_std_chk.sv
// Port-level checker for block_mean_and_std, attached by the bind below.
// Depends on bms_pkg for field widths and result bounds.
`default_nettype none

module block_mean_and_std_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             s_axis_tvalid,
    input wire logic                             s_axis_tready,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [bms_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import bms_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Every sample transfer is followed by the accumulate cycle
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("sample taken during accumulate");

    // A new result appears only out of the end-of-block pass
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without end-of-block pass");

    // Mean and deviation stay within the sample range
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[MEAN_W-1:0] <= MEAN_MAX) &&
                          (m_axis_tdata[MEAN_W+STD_W-1:MEAN_W] <= STD_MAX))
        else $error("result out of range");

endmodule

bind block_mean_and_std block_mean_and_std_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
